// ===== hdl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger: beat payloads,
// measurement phases, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int COUNT_BITS_DEF = 17;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_INDEX_W    = 3;
    localparam int DIST_W         = 17;
    localparam int SCALE_FRAC     = 16;

    localparam logic [7:0]  TRIG_LEN_RST    = 8'd20;
    localparam logic [15:0] RISE_TIMEOUT_RST = 16'd10000;
    localparam logic [7:0]  US_PER_COUNT_RST = 8'd9;
    localparam int          MAX_COUNT_RST    = 100000;
    localparam logic [15:0] SCALE_RST        = 16'd10027;

    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_LEN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_TIMEOUT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_US_PER_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COUNT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE        = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_TOOLONG = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } in_beat_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        status;
        logic [DIST_W-1:0] dist_cm;
    } out_beat_t;

endpackage

// ===== hdl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger/echo range finder stepped by one input beat per microsecond tick.
//
// s_ channel: one beat per microsecond, carrying start_req and echo_level.
// m_ channel: exactly one result beat per input beat, in order, giving the
//   trigger pin level, busy and done flags, last status and last distance.
// cfg channel: register writes by index (0 trigger length, 1 rise timeout,
//   2 microseconds per count, 3 max count, 4 Q0.16 scale); always ready.
// Datapath: an accepted beat is registered in the input register, processed by a single
//   pass of logic (one COUNT_BITS x 16 multiply at most), and its result is loaded into
//   the result register once that stage is free or its beat is being taken.
// Throughput: one beat per cycle while m_ready is high, with the input register and
//   the result register both advancing together.
// Reset (aresetn low, synchronous): phase idle, counters and last result
//   cleared, registers back to their defaults, both pipeline stages empty.
// Stall: while m_ready is low the result holds; one more beat may sit in the
//   input register, after which s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  uer_pkg::in_beat_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output uer_pkg::out_beat_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DIST_W = uer_pkg::DIST_W;
    localparam int FRAC   = uer_pkg::SCALE_FRAC;
    localparam int PROD_W = (COUNT_BITS + 16 > FRAC + DIST_W) ? COUNT_BITS + 16
                                                               : FRAC + DIST_W;

    // configuration
    logic [7:0]            trig_len_reg;
    logic [15:0]           rise_timeout_reg;
    logic [7:0]            us_per_count_reg;
    logic [COUNT_BITS-1:0] max_count_reg;
    logic [15:0]           scale_reg;

    // pipeline
    logic                  in_valid_reg;
    uer_pkg::in_beat_t     in_data_reg;
    logic                  m_valid_reg;
    uer_pkg::out_beat_t    m_data_reg;
    logic                  advance;

    // measurement state
    uer_pkg::phase_t       phase_reg, phase_next;
    logic [15:0]           us_counter_reg, us_counter_next;
    logic [7:0]            presc_reg, presc_next;
    logic [COUNT_BITS-1:0] echo_count_reg, echo_count_next;
    logic [DIST_W-1:0]     last_dist_reg, last_dist_next;
    logic [1:0]            last_status_reg, last_status_next;
    uer_pkg::out_beat_t    result;

    // shared datapath
    logic                  start, echo;
    logic [COUNT_BITS-1:0] eff_count;
    logic [7:0]            eff_presc;
    logic                  tick_unit;
    logic [COUNT_BITS:0]   cnt_inc;
    logic                  tick_over;
    logic [7:0]            presc_inc;
    logic [7:0]            presc_new;
    logic [15:0]           wait_cnt;
    logic                  trig_end;
    logic                  fin_ok, fin_timeout, fin_toolong;
    logic [COUNT_BITS+15:0] prod_raw;
    logic [PROD_W-1:0]     prod;
    logic [DIST_W-1:0]     dist_calc;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign start = in_data_reg.start_req;
    assign echo  = in_data_reg.echo_level;

    // on the rise tick the unit counter starts from zero
    assign eff_count = (phase_reg == uer_pkg::PH_WAIT) ? '0 : echo_count_reg;
    assign eff_presc = (phase_reg == uer_pkg::PH_WAIT) ? 8'd0 : presc_reg;
    assign tick_unit = (eff_presc == 8'd0);
    assign cnt_inc   = {1'b0, eff_count} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign tick_over = tick_unit && (cnt_inc > {1'b0, max_count_reg});
    assign presc_inc = eff_presc + 8'd1;
    assign presc_new = (presc_inc >= us_per_count_reg) ? 8'd0 : presc_inc;
    assign wait_cnt  = us_counter_reg + 16'd1;
    assign trig_end  = (us_counter_reg >= {8'd0, trig_len_reg});

    assign prod_raw  = echo_count_reg * scale_reg;
    assign prod      = PROD_W'(prod_raw);
    assign dist_calc = prod[FRAC +: DIST_W];

    assign fin_ok      = (phase_reg == uer_pkg::PH_MEAS) && !echo;
    assign fin_timeout = (phase_reg == uer_pkg::PH_WAIT) && !echo
                         && (wait_cnt >= rise_timeout_reg);
    assign fin_toolong = ((phase_reg == uer_pkg::PH_WAIT) || (phase_reg == uer_pkg::PH_MEAS))
                         && echo && tick_over;

    // next state
    always_comb begin
        phase_next       = phase_reg;
        us_counter_next  = us_counter_reg;
        presc_next       = presc_reg;
        echo_count_next  = echo_count_reg;
        last_dist_next   = last_dist_reg;
        last_status_next = last_status_reg;
        unique case (phase_reg)
            uer_pkg::PH_IDLE: begin
                if (start) begin
                    phase_next      = uer_pkg::PH_TRIG;
                    us_counter_next = 16'd1;
                end
            end
            uer_pkg::PH_TRIG: begin
                if (trig_end) begin
                    phase_next      = uer_pkg::PH_WAIT;
                    us_counter_next = 16'd0;
                end else begin
                    us_counter_next = us_counter_reg + 16'd1;
                end
            end
            uer_pkg::PH_WAIT: begin
                if (echo) begin
                    presc_next      = presc_new;
                    echo_count_next = cnt_inc[COUNT_BITS-1:0];
                    phase_next      = uer_pkg::PH_MEAS;
                end else begin
                    us_counter_next = wait_cnt;
                end
            end
            uer_pkg::PH_MEAS: begin
                if (echo) begin
                    presc_next = presc_new;
                    if (tick_unit) begin
                        echo_count_next = cnt_inc[COUNT_BITS-1:0];
                    end
                end
            end
            default: begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
        priority if (fin_toolong) begin
            phase_next       = uer_pkg::PH_IDLE;
            last_status_next = uer_pkg::ST_TOOLONG;
            last_dist_next   = '0;
        end else if (fin_timeout) begin
            phase_next       = uer_pkg::PH_IDLE;
            last_status_next = uer_pkg::ST_TIMEOUT;
            last_dist_next   = '0;
        end else if (fin_ok) begin
            phase_next       = uer_pkg::PH_IDLE;
            last_status_next = uer_pkg::ST_OK;
            last_dist_next   = dist_calc;
        end else begin
            phase_next = phase_next;
        end
    end

    // result beat
    always_comb begin
        result.trigger_level = ((phase_reg == uer_pkg::PH_IDLE) && start)
                               || ((phase_reg == uer_pkg::PH_TRIG) && !trig_end);
        result.busy_res      = (phase_next != uer_pkg::PH_IDLE);
        result.done_res      = fin_ok || fin_timeout || fin_toolong;
        result.status        = last_status_next;
        result.dist_cm       = last_dist_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_len_reg     <= uer_pkg::TRIG_LEN_RST;
            rise_timeout_reg <= uer_pkg::RISE_TIMEOUT_RST;
            us_per_count_reg <= uer_pkg::US_PER_COUNT_RST;
            max_count_reg    <= COUNT_BITS'(uer_pkg::MAX_COUNT_RST);
            scale_reg        <= uer_pkg::SCALE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                uer_pkg::CFG_TRIG_LEN:     trig_len_reg     <= cfg_data[7:0];
                uer_pkg::CFG_RISE_TIMEOUT: rise_timeout_reg <= cfg_data[15:0];
                uer_pkg::CFG_US_PER_COUNT: us_per_count_reg <= cfg_data[7:0];
                uer_pkg::CFG_MAX_COUNT:    max_count_reg    <= cfg_data[COUNT_BITS-1:0];
                uer_pkg::CFG_SCALE:        scale_reg        <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            phase_reg       <= uer_pkg::PH_IDLE;
            us_counter_reg  <= '0;
            presc_reg       <= '0;
            echo_count_reg  <= '0;
            last_dist_reg   <= '0;
            last_status_reg <= uer_pkg::ST_OK;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg     <= 1'b1;
                phase_reg       <= phase_next;
                us_counter_reg  <= us_counter_next;
                presc_reg       <= presc_next;
                echo_count_reg  <= echo_count_next;
                last_dist_reg   <= last_dist_next;
                last_status_reg <= last_status_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    // checks
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done beat reports busy");

    a_error_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != uer_pkg::ST_OK) |-> (m_data.dist_cm == '0))
        else $error("error status with nonzero distance");

    a_trig_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.trigger_level |-> m_data.busy_res)
        else $error("trigger high while not busy");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with free stage");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_reg))
        else $error("stalled result changed");

endmodule

// ===== sim/uer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_checker
// Watches the input, result and register channels of the echo ranger. Every
// input beat steps a local copy of the ranger and queues the result beat it
// must produce; every result beat is compared field by field with the oldest
// queued one. Mismatch and progress counts go back to the testbench top.
// ----------------------------------------------------------------------------
module uer_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  uer_pkg::in_beat_t               s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  uer_pkg::out_beat_t              m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              beats_owed,
    output int                              beats_checked,
    output int                              n_ok,
    output int                              n_timeout,
    output int                              n_toolong
);

    localparam int CW     = uer_pkg::COUNT_BITS_DEF;
    localparam int DIST_W = uer_pkg::DIST_W;

    logic [7:0]         trig_len;
    logic [15:0]        rise_timeout;
    logic [7:0]         us_per_cnt;
    logic [CW-1:0]      max_cnt;
    logic [15:0]        scale;

    uer_pkg::phase_t    ph;
    logic [15:0]        us_cnt;
    logic [7:0]         pre_cnt;
    logic [CW-1:0]      echo_cnt;
    logic [DIST_W-1:0]  dist_hold;
    logic [1:0]         st_hold;

    uer_pkg::out_beat_t beat_q[$];
    int                 bad = 0;
    int                 checked = 0;
    int                 ok_cnt = 0;
    int                 to_cnt = 0;
    int                 tl_cnt = 0;

    function automatic void end_measure(input logic [1:0] st,
                                        input logic [DIST_W-1:0] d);
        st_hold   = st;
        dist_hold = d;
        ph        = uer_pkg::PH_IDLE;
    endfunction

    // one echo-high microsecond; returns 1 when the count overflows
    function automatic logic echo_unit();
        logic [CW:0] nxt;
        if (pre_cnt == 8'd0) begin
            nxt = {1'b0, echo_cnt} + 1'b1;
            if (nxt > {1'b0, max_cnt}) begin
                end_measure(uer_pkg::ST_TOOLONG, '0);
                return 1'b1;
            end
            echo_cnt = nxt[CW-1:0];
        end
        pre_cnt = pre_cnt + 8'd1;
        if (pre_cnt >= us_per_cnt)
            pre_cnt = 8'd0;
        return 1'b0;
    endfunction

    task automatic step_ranger(input uer_pkg::in_beat_t b, output uer_pkg::out_beat_t o);
        logic           trig;
        logic           done;
        logic [CW+15:0] prod;
        trig = 1'b0;
        done = 1'b0;
        unique case (ph)
            uer_pkg::PH_IDLE: begin
                if (b.start_req) begin
                    ph     = uer_pkg::PH_TRIG;
                    us_cnt = 16'd1;
                    trig   = 1'b1;
                end
            end
            uer_pkg::PH_TRIG: begin
                if (us_cnt >= {8'd0, trig_len}) begin
                    ph     = uer_pkg::PH_WAIT;
                    us_cnt = 16'd0;
                end else begin
                    us_cnt = us_cnt + 16'd1;
                    trig   = 1'b1;
                end
            end
            uer_pkg::PH_WAIT: begin
                if (b.echo_level) begin
                    ph       = uer_pkg::PH_MEAS;
                    pre_cnt  = 8'd0;
                    echo_cnt = '0;
                    done     = echo_unit();
                end else begin
                    us_cnt = us_cnt + 16'd1;
                    if (us_cnt >= rise_timeout) begin
                        end_measure(uer_pkg::ST_TIMEOUT, '0);
                        done = 1'b1;
                    end
                end
            end
            default: begin
                if (b.echo_level) begin
                    done = echo_unit();
                end else begin
                    prod = echo_cnt * scale;
                    end_measure(uer_pkg::ST_OK, prod[16 +: DIST_W]);
                    done = 1'b1;
                end
            end
        endcase
        o.trigger_level = trig;
        o.busy_res      = (ph != uer_pkg::PH_IDLE);
        o.done_res      = done;
        o.status        = st_hold;
        o.dist_cm       = dist_hold;
    endtask

    always @(posedge aclk) begin
        uer_pkg::out_beat_t want;
        uer_pkg::out_beat_t got;
        if (!aresetn) begin
            trig_len     = uer_pkg::TRIG_LEN_RST;
            rise_timeout = uer_pkg::RISE_TIMEOUT_RST;
            us_per_cnt   = uer_pkg::US_PER_COUNT_RST;
            max_cnt      = CW'(uer_pkg::MAX_COUNT_RST);
            scale        = uer_pkg::SCALE_RST;
            ph           = uer_pkg::PH_IDLE;
            us_cnt       = '0;
            pre_cnt      = '0;
            echo_cnt     = '0;
            dist_hold    = '0;
            st_hold      = uer_pkg::ST_OK;
            beat_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    uer_pkg::CFG_TRIG_LEN:     trig_len     = cfg_data[7:0];
                    uer_pkg::CFG_RISE_TIMEOUT: rise_timeout = cfg_data[15:0];
                    uer_pkg::CFG_US_PER_COUNT: us_per_cnt   = cfg_data[7:0];
                    uer_pkg::CFG_MAX_COUNT:    max_cnt      = cfg_data[CW-1:0];
                    uer_pkg::CFG_SCALE:        scale        = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (beat_q.size() == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display({"unexpected result beat: trig=%0b busy=%0b ",
                                  "done=%0b st=%0d dist=%0d"},
                                 got.trigger_level, got.busy_res, got.done_res,
                                 got.status, got.dist_cm);
                end else begin
                    want = beat_q.pop_front();
                    if (got.trigger_level !== want.trigger_level ||
                        got.busy_res !== want.busy_res ||
                        got.done_res !== want.done_res ||
                        got.status !== want.status ||
                        got.dist_cm !== want.dist_cm) begin
                        bad++;
                        if (bad <= 10)
                            $display({"mismatch at result beat %0d: expected trig=%0b ",
                                      "busy=%0b done=%0b st=%0d dist=%0d, got trig=%0b ",
                                      "busy=%0b done=%0b st=%0d dist=%0d"},
                                     checked, want.trigger_level, want.busy_res,
                                     want.done_res, want.status, want.dist_cm,
                                     got.trigger_level, got.busy_res, got.done_res,
                                     got.status, got.dist_cm);
                    end
                    checked++;
                    if (want.done_res) begin
                        unique case (want.status)
                            uer_pkg::ST_OK:      ok_cnt++;
                            uer_pkg::ST_TIMEOUT: to_cnt++;
                            default:             tl_cnt++;
                        endcase
                    end
                end
            end
            if (s_valid && s_ready) begin
                step_ranger(s_data, want);
                beat_q.push_back(want);
            end
        end
        mismatches    <= bad;
        beats_owed    <= beat_q.size();
        beats_checked <= checked;
        n_ok          <= ok_cnt;
        n_timeout     <= to_cnt;
        n_toolong     <= tl_cnt;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the ultrasonic echo ranger. Drives microsecond ticks as
// whole trigger/echo measurements with random timing plus stray noise,
// rewrites the registers between phases (zero, small and full-scale
// settings), idles the sender in bursts and stalls the receiver, and leaves
// all checking to uer_checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_GOAL   = 700;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    uer_pkg::in_beat_t               s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    uer_pkg::out_beat_t              m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches, beats_owed, beats_checked, n_ok, n_timeout, n_toolong;

    int cur_tl  = uer_pkg::TRIG_LEN_RST;
    int cur_rt  = uer_pkg::RISE_TIMEOUT_RST;
    int cur_upc = uer_pkg::US_PER_COUNT_RST;
    int cur_mc  = uer_pkg::MAX_COUNT_RST;
    int gap_left    = 0;
    int burst_left  = 0;
    bit sender_calm = 1'b1;
    int rx_mode     = 0;
    int rx_tick     = 0;
    int quiet       = 0;
    int sent        = 0;

    ultrasonic_echo_ranger u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    uer_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .beats_owed    (beats_owed),
        .beats_checked (beats_checked),
        .n_ok          (n_ok),
        .n_timeout     (n_timeout),
        .n_toolong     (n_toolong)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        unique case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ((rx_tick % 13) < 8);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_tick(input logic st, input logic ec);
        uer_pkg::in_beat_t b;
        b.start_req  = st;
        b.echo_level = ec;
        if (gap_left > 0) begin
            s_valid <= 1'b0;
            repeat (gap_left) @(posedge aclk);
            gap_left = 0;
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = sender_calm ? 0 : $urandom_range(1, 5);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (beats_owed != 0);
    endtask

    task automatic put_reg(input logic [uer_pkg::CFG_INDEX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_regs(input int tl, input int rt, input int upc, input int mc,
                            input int sc);
        drain();
        put_reg(uer_pkg::CFG_TRIG_LEN, tl);
        put_reg(uer_pkg::CFG_RISE_TIMEOUT, rt);
        put_reg(uer_pkg::CFG_US_PER_COUNT, upc);
        put_reg(uer_pkg::CFG_MAX_COUNT, mc);
        put_reg(uer_pkg::CFG_SCALE, sc);
        cfg_valid   <= 1'b0;
        cur_tl      = tl;
        cur_rt      = rt;
        cur_upc     = upc;
        cur_mc      = mc;
        sender_calm = ($urandom_range(0, 2) == 0);
        rx_mode     <= $urandom_range(0, 2);
    endtask

    // start tick, rest of the trigger, low wait, echo pulse, falling tick
    task automatic measure(input int wait_low, input int high_len);
        int tl_eff;
        tl_eff = (cur_tl == 0) ? 1 : cur_tl;
        push_tick(1'b1, $urandom_range(0, 1));
        repeat (tl_eff) push_tick($urandom_range(0, 1), $urandom_range(0, 1));
        repeat (wait_low) push_tick(1'b0, 1'b0);
        repeat (high_len) push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
    endtask

    task automatic noise(input int n);
        repeat (n) push_tick(($urandom_range(0, 7) == 0), $urandom_range(0, 1));
    endtask

    initial begin
        int phase_end;
        int upc_eff;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        measure(2, 60);

        set_regs(2, 4, 2, 5, 65535);
        measure(1, 3);
        measure(0, 1);
        measure(4, 0);
        measure(0, 11);
        measure(1, 10);

        set_regs(0, 0, 0, 0, 0);
        measure(0, 1);
        measure(0, 0);

        set_regs(1, 3, 0, 7, 0);
        measure(2, 4);

        set_regs(255, 65535, 255, 131071, 65535);
        sender_calm = 1'b1;
        measure(0, 1);

        set_regs(3, 20, 1, 131071, 65535);
        measure(2, 150);

        while (sent < ITEM_GOAL) begin
            set_regs($urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 3),
                     $urandom_range(0, 20), $urandom_range(0, 65535));
            upc_eff   = (cur_upc == 0) ? 1 : cur_upc;
            phase_end = sent + $urandom_range(30, 60);
            while (sent < phase_end) begin
                if ($urandom_range(0, 4) == 0)
                    noise($urandom_range(1, 12));
                else
                    measure($urandom_range(0, cur_rt + 2),
                            $urandom_range(0, cur_mc * upc_eff + 3));
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("%0d ticks driven, %0d result beats compared, %0d mismatches",
                 sent, beats_checked, mismatches);
        $display("measurements ended: %0d ok, %0d rise timeout, %0d too long",
                 n_ok, n_timeout, n_toolong);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/uer_pkg.sv
hdl/ultrasonic_echo_ranger.sv
sim/uer_checker.sv
sim/tb.sv
